// File: design/pae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pae_pkg: shared types and codes for the slot pool
// Request and status codes, and the fixed widths of the command and result
// words.
// ----------------------------------------------------------------------------
package pae_pkg;

    localparam int SLOT_W   = 8;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 3;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // request codes
    localparam req_t REQ_ALLOC = 2'd0;
    localparam req_t REQ_FREE  = 2'd1;
    localparam req_t REQ_CLEAR = 2'd2;

    // status codes
    localparam status_t ST_TOOK    = 3'd0;
    localparam status_t ST_EVICT   = 3'd1;
    localparam status_t ST_FREED   = 3'd2;
    localparam status_t ST_IGNORED = 3'd3;
    localparam status_t ST_CLEARED = 3'd4;

endpackage

// File: design/pae_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pae_link_ram: one-write, one-read link memory
// Registered read; a write to the address being read in the same cycle is
// returned as the read data (write-first).
// ----------------------------------------------------------------------------
module pae_link_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 9,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // forward a same-cycle write to the read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/pool_alloc_evict_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_alloc_evict_oldest: slot pool with free stack and oldest-first eviction
// Hands out slots from a fixed pool, keeps the active slots in a list ordered
// newest first, and evicts the oldest active slot when the pool runs dry.
// ----------------------------------------------------------------------------
//
// A request word (req_type, slot_index) is taken when start is high and busy
// is low. Busy is high in the cycle after the accept, so the block takes no
// new request in that cycle; the stall is set by the link memories,
// whose registered read of the chosen slot's neighbors must land before the
// list can be relinked. The result word (slot, status) appears on the cycle
// after that, marked by a one-cycle done strobe; the receiver cannot stall it
// and must take it then. Every request, including a reserved code, gives
// exactly one result. Allocate takes the most recently freed slot, else the
// next never-used slot in ascending order, else the oldest active slot.
// Free of an inactive or out-of-range slot changes nothing. Clear empties the
// pool in one request. Reset and clear need no sweep of the memories: the
// link memories hold garbage until written, and an active mark is only
// trusted for slots below the count of slots handed out since the last clear,
// all of which were written when handed out.
//
module pool_alloc_evict_oldest #(
    parameter int POOL_SLOTS = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  pae_pkg::req_t           req_type,
    input  pae_pkg::slot_t          slot_index,
    output logic                    busy,
    output logic                    done,
    output pae_pkg::slot_t          slot,
    output pae_pkg::status_t        status
);

    localparam int AW = $clog2(POOL_SLOTS);   // slot address bits
    localparam int LW = AW + 1;               // link bits, room for the none mark
    localparam int CW = (LW > pae_pkg::SLOT_W + 1) ? LW : pae_pkg::SLOT_W + 1;
    localparam logic [LW-1:0] NIL = LW'(POOL_SLOTS);

    // ------------------------------------------------------------------
    // Request capture
    // ------------------------------------------------------------------
    logic                   accept;
    logic                   work_reg;
    pae_pkg::req_t          req_reg;
    pae_pkg::slot_t         idx_reg;

    // ------------------------------------------------------------------
    // Pool state
    // ------------------------------------------------------------------
    logic [LW-1:0]          ft_reg,     ft_next;      // top of free stack
    logic [LW-1:0]          fc_reg,     fc_next;      // slots handed out
    logic [LW-1:0]          newest_reg, newest_next;
    logic [LW-1:0]          oldest_reg, oldest_next;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic [AW-1:0]          rd_addr;
    logic [LW-1:0]          nxt_rd, prv_rd;
    logic [0:0]             act_rd;

    logic                   nx1_we, pv1_we, act_we;
    logic [AW-1:0]          nx1_addr, pv1_addr, act_addr;
    logic [LW-1:0]          nx1_data, pv1_data;
    logic [0:0]             act_data;

    logic                   nx2_we_reg, nx2_we_next;
    logic [AW-1:0]          nx2_addr_reg, nx2_addr_next;
    logic [LW-1:0]          nx2_data_reg, nx2_data_next;
    logic                   pv2_we_reg, pv2_we_next;
    logic [AW-1:0]          pv2_addr_reg, pv2_addr_next;
    logic [LW-1:0]          pv2_data_reg, pv2_data_next;

    logic                   nx_we, pv_we;
    logic [AW-1:0]          nx_addr, pv_addr;
    logic [LW-1:0]          nx_data, pv_data;

    // ------------------------------------------------------------------
    // Update path signals
    // ------------------------------------------------------------------
    logic                   ft_ok, fc_ok, old_ok, p_ok, n_ok, nw_ok;
    logic [CW-1:0]          in_idx_ext, idx_ext;
    logic                   idx_hit;
    logic                   evict, push;
    logic [LW-1:0]          s, nw;
    logic [CW-1:0]          res_slot;
    pae_pkg::status_t       res_status;

    logic                   done_reg;
    logic [CW-1:0]          slot_reg;
    pae_pkg::status_t       status_reg;

    assign accept = start && !work_reg;
    assign busy   = work_reg;

    // Pick the slot whose links the request will need: the slot to free, or
    // the allocation candidate (stack top, then oldest). Never-used slots
    // need no read.
    assign in_idx_ext = CW'(slot_index);
    assign ft_ok      = ft_reg < NIL;
    assign old_ok     = oldest_reg < NIL;

    always_comb
    begin
        rd_addr = '0;
        if (req_type == pae_pkg::REQ_FREE)
        begin
            if (in_idx_ext < CW'(POOL_SLOTS))
            begin
                rd_addr = in_idx_ext[AW-1:0];
            end
        end
        else if (ft_ok)
        begin
            rd_addr = ft_reg[AW-1:0];
        end
        else if (old_ok)
        begin
            rd_addr = oldest_reg[AW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Link memories and active marks
    // ------------------------------------------------------------------
    // The second link write of a request lands in the cycle after the first,
    // in the cycle where the next request may read; the RAM forwards it.
    assign nx_we   = work_reg ? nx1_we   : nx2_we_reg;
    assign nx_addr = work_reg ? nx1_addr : nx2_addr_reg;
    assign nx_data = work_reg ? nx1_data : nx2_data_reg;
    assign pv_we   = work_reg ? pv1_we   : pv2_we_reg;
    assign pv_addr = work_reg ? pv1_addr : pv2_addr_reg;
    assign pv_data = work_reg ? pv1_data : pv2_data_reg;

    pae_link_ram #(
        .DEPTH  (POOL_SLOTS),
        .WIDTH  (LW),
        .ADDR_W (AW)
    ) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_addr),
        .wdata (nx_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (nxt_rd)
    );

    pae_link_ram #(
        .DEPTH  (POOL_SLOTS),
        .WIDTH  (LW),
        .ADDR_W (AW)
    ) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_addr),
        .wdata (pv_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (prv_rd)
    );

    pae_link_ram #(
        .DEPTH  (POOL_SLOTS),
        .WIDTH  (1),
        .ADDR_W (AW)
    ) u_active_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_addr),
        .wdata (act_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (act_rd)
    );

    // ------------------------------------------------------------------
    // List update, in the cycle after accept
    // ------------------------------------------------------------------
    assign fc_ok   = fc_reg < NIL;
    assign p_ok    = prv_rd < NIL;
    assign n_ok    = nxt_rd < NIL;
    assign idx_ext = CW'(idx_reg);
    // a slot at or above the handed-out count was never used: its mark is stale
    assign idx_hit = (idx_ext < CW'(fc_reg)) && act_rd[0];

    always_comb
    begin
        ft_next       = ft_reg;
        fc_next       = fc_reg;
        newest_next   = newest_reg;
        oldest_next   = oldest_reg;
        nx1_we        = 1'b0;
        nx1_addr      = '0;
        nx1_data      = '0;
        pv1_we        = 1'b0;
        pv1_addr      = '0;
        pv1_data      = '0;
        nx2_we_next   = 1'b0;
        nx2_addr_next = '0;
        nx2_data_next = '0;
        pv2_we_next   = 1'b0;
        pv2_addr_next = '0;
        pv2_data_next = '0;
        act_we        = 1'b0;
        act_addr      = '0;
        act_data      = 1'b0;
        evict         = 1'b0;
        push          = 1'b0;
        s             = '0;
        nw            = NIL;
        nw_ok         = 1'b0;
        res_slot      = '0;
        res_status    = pae_pkg::ST_IGNORED;

        if (work_reg)
        begin
            unique case (req_reg)
                pae_pkg::REQ_ALLOC:
                begin
                    res_status = pae_pkg::ST_TOOK;
                    if (ft_ok)
                    begin
                        // pop the free stack
                        s       = ft_reg;
                        ft_next = n_ok ? nxt_rd : NIL;
                        push    = 1'b1;
                    end
                    else if (fc_ok)
                    begin
                        s       = fc_reg;
                        fc_next = fc_reg + LW'(1);
                        push    = 1'b1;
                    end
                    else
                    begin
                        res_status = pae_pkg::ST_EVICT;
                        if (old_ok)
                        begin
                            s     = oldest_reg;
                            evict = 1'b1;
                            push  = 1'b1;
                        end
                    end

                    if (push)
                    begin
                        // newest after unlinking the evicted tail
                        nw    = (evict && !p_ok) ? NIL : newest_reg;
                        nw_ok = nw < NIL;
                        if (evict && p_ok)
                        begin
                            nx1_we        = 1'b1;
                            nx1_addr      = prv_rd[AW-1:0];
                            nx1_data      = NIL;
                            nx2_we_next   = 1'b1;
                            nx2_addr_next = s[AW-1:0];
                            nx2_data_next = nw;
                        end
                        else
                        begin
                            nx1_we   = 1'b1;
                            nx1_addr = s[AW-1:0];
                            nx1_data = nw;
                        end
                        pv1_we   = 1'b1;
                        pv1_addr = s[AW-1:0];
                        pv1_data = NIL;
                        if (nw_ok)
                        begin
                            pv2_we_next   = 1'b1;
                            pv2_addr_next = nw[AW-1:0];
                            pv2_data_next = s;
                        end
                        act_we      = 1'b1;
                        act_addr    = s[AW-1:0];
                        act_data    = 1'b1;
                        newest_next = s;
                        if (!nw_ok)
                        begin
                            oldest_next = s;
                        end
                        else if (evict)
                        begin
                            oldest_next = prv_rd;
                        end
                        res_slot = CW'(s);
                    end
                end

                pae_pkg::REQ_FREE:
                begin
                    res_slot = idx_ext;
                    if (idx_hit)
                    begin
                        res_status = pae_pkg::ST_FREED;
                        // unlink from the active list
                        if (p_ok)
                        begin
                            nx1_we   = 1'b1;
                            nx1_addr = prv_rd[AW-1:0];
                            nx1_data = nxt_rd;
                        end
                        else
                        begin
                            newest_next = nxt_rd;
                        end
                        if (n_ok)
                        begin
                            pv1_we   = 1'b1;
                            pv1_addr = nxt_rd[AW-1:0];
                            pv1_data = prv_rd;
                        end
                        else
                        begin
                            oldest_next = prv_rd;
                        end
                        // push onto the free stack
                        nx2_we_next   = 1'b1;
                        nx2_addr_next = idx_ext[AW-1:0];
                        nx2_data_next = ft_reg;
                        ft_next       = idx_ext[LW-1:0];
                        act_we        = 1'b1;
                        act_addr      = idx_ext[AW-1:0];
                        act_data      = 1'b0;
                    end
                end

                pae_pkg::REQ_CLEAR:
                begin
                    ft_next     = NIL;
                    fc_next     = '0;
                    newest_next = NIL;
                    oldest_next = NIL;
                    res_status  = pae_pkg::ST_CLEARED;
                end

                default:
                begin
                    res_status = pae_pkg::ST_IGNORED;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg   <= 1'b0;
            done_reg   <= 1'b0;
            nx2_we_reg <= 1'b0;
            pv2_we_reg <= 1'b0;
            ft_reg     <= NIL;
            fc_reg     <= '0;
            newest_reg <= NIL;
            oldest_reg <= NIL;
        end
        else
        begin
            work_reg   <= accept;
            done_reg   <= work_reg;
            // second link writes are held here until they are performed
            nx2_we_reg <= nx2_we_next;
            pv2_we_reg <= pv2_we_next;
            ft_reg     <= ft_next;
            fc_reg     <= fc_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            idx_reg <= slot_index;
        end
        if (work_reg)
        begin
            slot_reg   <= res_slot;
            status_reg <= res_status;
        end
        nx2_addr_reg <= nx2_addr_next;
        nx2_data_reg <= nx2_data_next;
        pv2_addr_reg <= pv2_addr_next;
        pv2_data_reg <= pv2_data_next;
    end

    assign done   = done_reg;
    assign slot   = slot_reg[pae_pkg::SLOT_W-1:0];
    assign status = status_reg;

endmodule

// File: sim/tb_pool_alloc_evict_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pool_alloc_evict_oldest: self-checking bench for the slot pool
// Sends allocate, free, clear and reserved request words. Directed words come
// first, then random episodes that churn the pool, some after filling it
// until it evicts. A shadow of the pool predicts each result word, and the
// monitor compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_pool_alloc_evict_oldest;

    localparam int POOL       = 256;
    localparam int NIL        = POOL;       // "no slot" in the shadow links
    localparam int ITEMS      = 1750;       // random words that do something
    localparam int IDLE_LIMIT = 1000;       // cycles with no word moving
    localparam int TAIL       = 8;          // cycles to wait after the last result
    localparam pae_pkg::req_t REQ_RSVD = 2'd3;  // reserved request code

    // shadow views: one steers the generator, one checks the block
    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    typedef struct packed {
        pae_pkg::req_t  req;
        pae_pkg::slot_t idx;
    } cmd_word_t;

    typedef struct packed {
        pae_pkg::slot_t   slot;
        pae_pkg::status_t status;
    } result_word_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             start      = 1'b0;
    pae_pkg::req_t    req_type   = pae_pkg::REQ_ALLOC;
    pae_pkg::slot_t   slot_index = '0;
    logic             busy;
    logic             done;
    pae_pkg::slot_t   slot;
    pae_pkg::status_t status;

    pool_alloc_evict_oldest #(
        .POOL_SLOTS (POOL)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .slot_index (slot_index),
        .busy       (busy),
        .done       (done),
        .slot       (slot),
        .status     (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow pool. Each slot is never used, on the free stack, or on the
    // active list. The active list runs newest to oldest through toward_older;
    // the free stack also chains through toward_older.
    // ------------------------------------------------------------------------
    int toward_older [2][POOL];
    int toward_newer [2][POOL];
    bit live         [2][POOL];
    int stack_top    [2];
    int handed       [2];      // slots handed out fresh since the last clear
    int newest       [2];
    int oldest       [2];

    function automatic void empty_pool(input int v);
        for (int i = 0; i < POOL; i++)
        begin
            toward_older[v][i] = 0;
            toward_newer[v][i] = 0;
            live[v][i]         = 1'b0;
        end
        stack_top[v] = NIL;
        handed[v]    = 0;
        newest[v]    = NIL;
        oldest[v]    = NIL;
    endfunction

    function automatic void unlink_slot(input int v, input int s);
        int p;
        int n;
        p = toward_newer[v][s];
        n = toward_older[v][s];
        if (p < NIL) toward_older[v][p] = n; else newest[v] = n;
        if (n < NIL) toward_newer[v][n] = p; else oldest[v] = p;
    endfunction

    function automatic void make_newest(input int v, input int s);
        toward_newer[v][s] = NIL;
        toward_older[v][s] = newest[v];
        if (newest[v] < NIL) toward_newer[v][newest[v]] = s;
        else oldest[v] = s;
        newest[v]  = s;
        live[v][s] = 1'b1;
    endfunction

    // Apply one request word to a shadow view and return the result word.
    function automatic result_word_t pool_request(input int v, input cmd_word_t w);
        result_word_t r;
        int s;
        s        = 0;
        r.status = pae_pkg::ST_IGNORED;
        case (w.req)
            pae_pkg::REQ_ALLOC:
            begin
                if (stack_top[v] < NIL)
                begin
                    s            = stack_top[v];
                    stack_top[v] = toward_older[v][s];
                    if (stack_top[v] > NIL) stack_top[v] = NIL;
                    make_newest(v, s);
                    r.status = pae_pkg::ST_TOOK;
                end
                else if (handed[v] < NIL)
                begin
                    s         = handed[v];
                    handed[v] = handed[v] + 1;
                    make_newest(v, s);
                    r.status = pae_pkg::ST_TOOK;
                end
                else if (oldest[v] < NIL)
                begin
                    s = oldest[v];
                    unlink_slot(v, s);
                    make_newest(v, s);
                    r.status = pae_pkg::ST_EVICT;
                end
                else
                begin
                    r.status = pae_pkg::ST_EVICT;
                end
            end
            pae_pkg::REQ_FREE:
            begin
                s = w.idx;
                if (live[v][s])
                begin
                    unlink_slot(v, s);
                    toward_older[v][s] = stack_top[v];
                    stack_top[v]       = s;
                    live[v][s]         = 1'b0;
                    r.status           = pae_pkg::ST_FREED;
                end
            end
            pae_pkg::REQ_CLEAR:
            begin
                empty_pool(v);
                r.status = pae_pkg::ST_CLEARED;
            end
            default:
            begin
                r.status = pae_pkg::ST_IGNORED;
            end
        endcase
        r.slot = pae_pkg::slot_t'(s);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generation, steered by the PLAN view
    // ------------------------------------------------------------------------
    cmd_word_t    pending_words [$];
    result_word_t due_results   [$];
    int           useful_words;     // random words that are not ignored
    int           bad_words;

    task automatic send_word(input pae_pkg::req_t rq, input int idx);
        cmd_word_t    w;
        result_word_t r;
        w.req = rq;
        w.idx = pae_pkg::slot_t'(idx);
        r     = pool_request(PLAN, w);
        pending_words.push_back(w);
        if (r.status != pae_pkg::ST_IGNORED) useful_words++;
    endtask

    // Pick an active slot at random; -1 when the active list is empty.
    function automatic int pick_live_slot();
        int cand [$];
        for (int i = 0; i < POOL; i++)
            if (live[PLAN][i]) cand.push_back(i);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    // Free a live slot, or fall back to an allocate when nothing is active.
    task automatic free_live_slot();
        int s;
        s = pick_live_slot();
        if (s < 0) send_word(pae_pkg::REQ_ALLOC, $urandom_range(0, 255));
        else send_word(pae_pkg::REQ_FREE, s);
    endtask

    // Words that change nothing or break the pattern: stray frees,
    // double frees, reserved codes, and the odd clear.
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_word(pae_pkg::REQ_FREE, $urandom_range(0, 255));
            1: send_word(REQ_RSVD, $urandom_range(0, 255));
            2: send_word(pae_pkg::REQ_FREE,
                         (stack_top[PLAN] < NIL) ? stack_top[PLAN]
                                                 : $urandom_range(0, 255));
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    send_word(pae_pkg::REQ_CLEAR, $urandom_range(0, 255));
                else
                    send_word(pae_pkg::REQ_FREE, $urandom_range(0, 255));
            end
        endcase
    endtask

    task automatic send_mixed(input int alloc_pct, input int free_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) send_word(pae_pkg::REQ_ALLOC, $urandom_range(0, 255));
        else if (r < alloc_pct + free_pct) free_live_slot();
        else send_noise();
    endtask

    task automatic build_stimulus();
        bit           deep;
        bit           first;
        int           evict_goal;
        int           evicts;
        int           n;
        result_word_t r;

        empty_pool(PLAN);

        // directed: fresh order, stack reuse order, list ends, double free,
        // top index, reserved code, clear, and ignored index fields
        send_word(pae_pkg::REQ_ALLOC, 0);
        send_word(pae_pkg::REQ_ALLOC, 255);
        send_word(pae_pkg::REQ_ALLOC, 0);
        send_word(pae_pkg::REQ_FREE, 1);          // middle of the active list
        send_word(pae_pkg::REQ_FREE, 1);          // double free
        send_word(pae_pkg::REQ_FREE, 255);        // never-used top index
        send_word(pae_pkg::REQ_FREE, 0);          // oldest
        send_word(pae_pkg::REQ_FREE, 2);          // newest and last active
        send_word(pae_pkg::REQ_ALLOC, 0);         // most recently freed first
        send_word(pae_pkg::REQ_ALLOC, 0);
        send_word(pae_pkg::REQ_ALLOC, 0);
        send_word(pae_pkg::REQ_ALLOC, 170);       // stack empty: next fresh slot
        send_word(REQ_RSVD, 255);
        send_word(pae_pkg::REQ_FREE, 3);
        send_word(pae_pkg::REQ_CLEAR, 85);
        send_word(pae_pkg::REQ_FREE, 0);          // inactive after clear
        send_word(pae_pkg::REQ_ALLOC, 255);
        send_word(REQ_RSVD, 0);
        send_word(pae_pkg::REQ_FREE, 0);          // only active slot
        send_word(pae_pkg::REQ_CLEAR, 255);
        send_word(pae_pkg::REQ_ALLOC, 0);

        // random episodes; the first one always fills the pool to eviction
        useful_words = 0;
        first        = 1'b1;
        while (useful_words < ITEMS)
        begin
            deep = first || ($urandom_range(0, 99) < 35);
            if (first || ($urandom_range(0, 9) != 0))
                send_word(pae_pkg::REQ_CLEAR, $urandom_range(0, 255));
            first = 1'b0;
            if (deep)
            begin
                evict_goal = $urandom_range(5, 40);
                evicts     = 0;
                while (evicts < evict_goal)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 85)
                    begin
                        cmd_word_t w;
                        w.req = pae_pkg::REQ_ALLOC;
                        w.idx = pae_pkg::slot_t'($urandom_range(0, 255));
                        r     = pool_request(PLAN, w);
                        pending_words.push_back(w);
                        useful_words++;
                        if (r.status == pae_pkg::ST_EVICT) evicts++;
                    end
                    else if (n < 95) free_live_slot();
                    else send_noise();
                end
                repeat ($urandom_range(40, 200)) send_mixed(50, 40);
            end
            else
            begin
                repeat ($urandom_range(10, 60)) send_mixed(55, 35);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: present words in bursts with random gaps; predict each word
    // from the CHECK view at the edge that accepts it.
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        cmd_word_t w;
        cmd_word_t taken;
        if (!rst_n)
        begin
            start      <= 1'b0;
            req_type   <= pae_pkg::REQ_ALLOC;
            slot_index <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // the word on the ports moves at this edge: predict its result
            if (start && !busy)
            begin
                taken.req = req_type;
                taken.idx = slot_index;
                due_results.push_back(pool_request(CHECK, taken));
            end

            if (start && busy)
            begin
                // hold the word until the block takes it
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                w = pending_words.pop_front();
                start      <= 1'b1;
                req_type   <= w.req;
                slot_index <= w.idx;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    // new burst; a zero gap or a long burst gives stretches
                    // with no idling at all
                    burst_left = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take each strobed result word and compare it with the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with no request pending: slot %0d status %0d", slot, status);
                bad_words++;
            end
            else
            begin
                want = due_results.pop_front();
                if (slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, slot);
                    bad_words++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    bad_words++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: drop the run when no word moves for too long.
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: build the words, release reset, drain, then judge.
    // ------------------------------------------------------------------------
    initial
    begin
        bad_words = 0;
        empty_pool(CHECK);
        build_stimulus();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // advance until every word is sent and every result has come back
        @(posedge clk);
        while (pending_words.size() > 0 || start || due_results.size() > 0)
            @(posedge clk);
        // catch any stray strobe after the last result
        repeat (TAIL) @(posedge clk);

        if (bad_words == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: filelist.f
design/pae_pkg.sv
design/pae_link_ram.sv
design/pool_alloc_evict_oldest.sv
sim/tb_pool_alloc_evict_oldest.sv
